// File: src/grhq_pkg.sv
package grhq_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_RECORDS_DEF     = 16;
  localparam int BYTE_COUNT_BITS_DEF = 20;

  // Fixed widths
  localparam int REC_BUDGET_W = 5;
  localparam int LEN_W        = 16;

  // Reset values of the configuration registers
  localparam int unsigned BYTE_BUDGET_RST = 32'd65536;
  localparam int unsigned REC_BUDGET_RST  = 32'd16;

  // Bytes of per-record prefix added to the payload length
  localparam int unsigned PREFIX_BYTES = 32'd6;

  // Configuration register indexes
  localparam logic CFG_BYTE_BUDGET = 1'b0;
  localparam logic CFG_REC_BUDGET  = 1'b1;

  // Command codes
  localparam logic [2:0] CMD_ENQUEUE = 3'd0;
  localparam logic [2:0] CMD_AUTH    = 3'd1;
  localparam logic [2:0] CMD_BIND    = 3'd2;
  localparam logic [2:0] CMD_LINK    = 3'd3;
  localparam logic [2:0] CMD_RELEASE = 3'd4;

  // Status codes
  localparam logic [2:0] ST_QUEUED       = 3'd0;
  localparam logic [2:0] ST_RELEASED     = 3'd1;
  localparam logic [2:0] ST_BLOCKED      = 3'd2;
  localparam logic [2:0] ST_CLOSED       = 3'd3;
  localparam logic [2:0] ST_INVALID      = 3'd4;
  localparam logic [2:0] ST_VIOLATION    = 3'd5;
  localparam logic [2:0] ST_BACKPRESSURE = 3'd6;

  typedef struct packed {
    logic [2:0]       command;
    logic [63:0]      flow_id;
    logic [63:0]      flow_seq;
    logic [31:0]      frame_tag;
    logic             type_name_present;
    logic [LEN_W-1:0] payload_length;
    logic [31:0]      payload_handle;
    logic             hs_done;
    logic             pin_ok;
    logic             exporter_ok;
    logic             local_side_ready;
    logic             remote_side_ready;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             record_valid;
    logic [63:0]      out_flow_id;
    logic [63:0]      out_sequence;
    logic [31:0]      out_tag;
    logic [LEN_W-1:0] out_length;
    logic [31:0]      out_handle;
    logic             last;
  } out_item_t;

endpackage

// File: src/gated_record_hold_queue_unit.sv
// Gated record hold queue.
// Input channel: a command transfer happens at a rising edge with start high and
// busy low; in_item carries the command and all of its operands. Enqueue stores
// a record descriptor, authenticate / bind / link ready step the gate, release
// drains the store once the gate is fully open.
// Result channel: out_strobe marks each result on out_item for one cycle; the
// receiver cannot hold results off. last marks the final result of a command.
// Config port: cfg_we with cfg_index 0 (byte budget) or 1 (record budget).
// Timing: results are strobed in the cycle after the busy period ends
// (registered outputs). Gate commands and refused or closed commands occupy
// only the decode state. An accepted enqueue goes from decode through the scan
// state, where the shared 128-bit compare walks the store one entry per cycle
// through its registered read port looking for a duplicate key (a hit ends the
// walk early; an empty store skips it), to the budget state for the budget
// add/compare and the store write. A release of an open gate drains the held
// records on consecutive cycles after decode, so the slowest item is an enqueue
// into a full store. The next command can start in the cycle the final result is strobed.
// Reset: store empty, gate closed, not failed, budgets at their defaults. The
// record store itself has no reset; only entries below the count are read.
module gated_record_hold_queue_unit
  import grhq_pkg::*;
#(
  parameter int MAX_RECORDS     = MAX_RECORDS_DEF,
  parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  in_item_t                   in_item,
  output logic                       out_strobe,
  output out_item_t                  out_item,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [BYTE_COUNT_BITS-1:0] cfg_data
);

  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int CMP_W = (CNT_W > REC_BUDGET_W) ? CNT_W : REC_BUDGET_W;
  localparam int SUM_W = ((BYTE_COUNT_BITS > LEN_W + 1) ? BYTE_COUNT_BITS : LEN_W + 1) + 1;

  typedef struct packed {
    logic [63:0]      sid;
    logic [63:0]      seq;
    logic [31:0]      tag;
    logic [LEN_W-1:0] len;
    logic [31:0]      hnd;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_BUDGET,
    S_DRAIN
  } state_t;

  state_t                     state_r, state_nxt;
  in_item_t                   in_r;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [BYTE_COUNT_BITS-1:0] total_r, total_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic                       failed_r, failed_nxt;
  logic                       released_r, released_nxt;
  logic                       auth_r, auth_nxt;
  logic                       bound_r, bound_nxt;
  logic                       rdy_loc_r, rdy_loc_nxt;
  logic                       rdy_rem_r, rdy_rem_nxt;
  logic                       out_strobe_r, out_strobe_nxt;
  out_item_t                  out_item_r, out_item_nxt;
  logic [BYTE_COUNT_BITS-1:0] byte_budget_r;
  logic [REC_BUDGET_W-1:0]    rec_budget_r;

  // Record store: one write port, one registered read port
  rec_t                       mem [MAX_RECORDS];
  rec_t                       rd_data_r;
  logic                       mem_we;
  logic                       accept;

  // Shared unit datapath
  logic                       key_match;
  logic                       at_end;
  logic [SUM_W-1:0]           new_total;
  logic                       over_budget;
  logic                       bad_args;
  logic                       gate_open;

  assign accept     = start && !busy;
  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;
  assign gate_open  = auth_r && bound_r && rdy_loc_r && rdy_rem_r;

  // Duplicate key compare against the entry read this cycle
  assign key_match = (rd_data_r.sid == in_r.flow_id) &&
                     (rd_data_r.seq == in_r.flow_seq);
  assign at_end    = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  // Budget check: count below both record limits, total+len+prefix <= byte budget
  assign new_total   = SUM_W'(total_r) + SUM_W'(in_r.payload_length) + SUM_W'(PREFIX_BYTES);
  assign over_budget = (CMP_W'(count_r) >= CMP_W'(rec_budget_r)) ||
                       (count_r == CNT_W'(MAX_RECORDS)) ||
                       (new_total > SUM_W'(byte_budget_r));

  assign bad_args = (byte_budget_r == '0) || (rec_budget_r == '0) ||
                    (in_r.flow_id == '0) || (in_r.flow_seq == '0) ||
                    (in_r.frame_tag == '0) || !in_r.type_name_present;

  function automatic logic [2:0] gate_st(input logic a, input logic b,
                                         input logic l, input logic r);
    gate_st = (a && b && l && r) ? ST_RELEASED : ST_BLOCKED;
  endfunction

  function automatic out_item_t simple(input logic [2:0] st);
    out_item_t o;
    o        = '0;
    o.status = st;
    o.last   = 1'b1;
    return o;
  endfunction

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    idx_nxt        = idx_r;
    failed_nxt     = failed_r;
    released_nxt   = released_r;
    auth_nxt       = auth_r;
    bound_nxt      = bound_r;
    rdy_loc_nxt    = rdy_loc_r;
    rdy_rem_nxt    = rdy_rem_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt      = S_IDLE;
        out_strobe_nxt = 1'b1;
        idx_nxt        = '0;
        unique case (in_r.command)
          CMD_ENQUEUE: begin
            priority if (bad_args) begin
              out_item_nxt = simple(ST_INVALID);
            end else if (failed_r || released_r || gate_open) begin
              out_item_nxt = simple(ST_CLOSED);
            end else begin
              out_strobe_nxt = 1'b0;
              state_nxt      = (count_r == '0) ? S_BUDGET : S_SCAN;
            end
          end
          CMD_AUTH: begin
            priority if (failed_r || released_r) begin
              out_item_nxt = simple(ST_CLOSED);
            end else if (!(in_r.hs_done && in_r.pin_ok &&
                           in_r.exporter_ok)) begin
              out_item_nxt = simple(ST_VIOLATION);
              failed_nxt   = 1'b1;
              count_nxt    = '0;
              total_nxt    = '0;
            end else begin
              auth_nxt     = 1'b1;
              out_item_nxt = simple(gate_st(1'b1, bound_r, rdy_loc_r, rdy_rem_r));
            end
          end
          CMD_BIND: begin
            priority if (failed_r || released_r) begin
              out_item_nxt = simple(ST_CLOSED);
            end else if (!auth_r) begin
              out_item_nxt = simple(ST_VIOLATION);
              failed_nxt   = 1'b1;
              count_nxt    = '0;
              total_nxt    = '0;
            end else begin
              bound_nxt    = 1'b1;
              out_item_nxt = simple(gate_st(auth_r, 1'b1, rdy_loc_r, rdy_rem_r));
            end
          end
          CMD_LINK: begin
            priority if (failed_r || released_r) begin
              out_item_nxt = simple(ST_CLOSED);
            end else if (!bound_r) begin
              out_item_nxt = simple(ST_VIOLATION);
              failed_nxt   = 1'b1;
              count_nxt    = '0;
              total_nxt    = '0;
            end else begin
              rdy_loc_nxt  = rdy_loc_r || in_r.local_side_ready;
              rdy_rem_nxt  = rdy_rem_r || in_r.remote_side_ready;
              out_item_nxt = simple(gate_st(auth_r, bound_r,
                                            rdy_loc_r || in_r.local_side_ready,
                                            rdy_rem_r || in_r.remote_side_ready));
            end
          end
          CMD_RELEASE: begin
            priority if (failed_r) begin
              out_item_nxt = simple(ST_CLOSED);
            end else if (released_r) begin
              out_item_nxt = simple(ST_RELEASED);
            end else if (!gate_open) begin
              out_item_nxt = simple(ST_BLOCKED);
            end else begin
              released_nxt = 1'b1;
              if (count_r == '0) begin
                out_item_nxt = simple(ST_RELEASED);
              end else begin
                out_strobe_nxt = 1'b0;
                state_nxt      = S_DRAIN;
              end
            end
          end
          default: begin
            out_item_nxt = simple(ST_INVALID);
          end
        endcase
      end

      // One stored key compared per cycle
      S_SCAN: begin
        priority if (key_match) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = simple(ST_VIOLATION);
          failed_nxt     = 1'b1;
          count_nxt      = '0;
          total_nxt      = '0;
          state_nxt      = S_IDLE;
        end else if (at_end) begin
          state_nxt = S_BUDGET;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_BUDGET: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
        if (over_budget) begin
          out_item_nxt = simple(ST_BACKPRESSURE);
          failed_nxt   = 1'b1;
          count_nxt    = '0;
          total_nxt    = '0;
        end else begin
          out_item_nxt = simple(ST_QUEUED);
          mem_we       = 1'b1;
          count_nxt    = count_r + CNT_W'(1);
          total_nxt    = new_total[BYTE_COUNT_BITS-1:0];
        end
      end

      // One record out per cycle
      S_DRAIN: begin
        out_strobe_nxt             = 1'b1;
        out_item_nxt.status        = ST_RELEASED;
        out_item_nxt.record_valid  = 1'b1;
        out_item_nxt.out_flow_id   = rd_data_r.sid;
        out_item_nxt.out_sequence  = rd_data_r.seq;
        out_item_nxt.out_tag       = rd_data_r.tag;
        out_item_nxt.out_length    = rd_data_r.len;
        out_item_nxt.out_handle    = rd_data_r.hnd;
        out_item_nxt.last          = at_end;
        if (at_end) begin
          count_nxt = '0;
          total_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Store: write at the fill count, read ahead at the next scan index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= '{sid: in_r.flow_id, seq: in_r.flow_seq,
                                   tag: in_r.frame_tag, len: in_r.payload_length,
                                   hnd: in_r.payload_handle};
    end
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
    out_item_r <= out_item_nxt;
    idx_r      <= idx_nxt;
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      total_r       <= '0;
      failed_r      <= 1'b0;
      released_r    <= 1'b0;
      auth_r        <= 1'b0;
      bound_r       <= 1'b0;
      rdy_loc_r     <= 1'b0;
      rdy_rem_r     <= 1'b0;
      out_strobe_r  <= 1'b0;
      byte_budget_r <= BYTE_COUNT_BITS'(BYTE_BUDGET_RST);
      rec_budget_r  <= REC_BUDGET_W'(REC_BUDGET_RST);
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      failed_r     <= failed_nxt;
      released_r   <= released_nxt;
      auth_r       <= auth_nxt;
      bound_r      <= bound_nxt;
      rdy_loc_r    <= rdy_loc_nxt;
      rdy_rem_r    <= rdy_rem_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BYTE_BUDGET: byte_budget_r <= cfg_data;
          CFG_REC_BUDGET:  rec_budget_r  <= cfg_data[REC_BUDGET_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/gated_record_hold_queue_unit_test.sv
module gated_record_hold_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import grhq_pkg::*;

  // Random-phase pacing: link-ready commands only from LINK_FROM on, and the
  // fatal paths (duplicate key, budget overrun, bad gate order) only from
  // FATAL_FROM on. Before that the store fills and the gate half-opens.
  localparam int RANDOM_ITEMS = 400;
  localparam int LINK_FROM    = 200;
  localparam int FATAL_FROM   = 250;
  localparam int CFG_EVERY    = 64;

  // One held record descriptor
  typedef struct packed {
    logic [63:0] sid;
    logic [63:0] seq;
    logic [31:0] tag;
    logic [15:0] len;
    logic [31:0] hnd;
  } held_rec_t;

  // Mirror of the hold queue: tracks the store, the gate and the budgets,
  // turns each accepted command into the results it must produce and checks
  // them against what comes out of the block.
  class hold_queue_mirror;
    held_rec_t       held[MAX_RECORDS_DEF];
    int unsigned     count;
    longint unsigned bytes;
    bit              failed;
    bit              released;
    bit              authed;
    bit              bound;
    bit              rdy_local;
    bit              rdy_remote;
    longint unsigned byte_budget;
    int unsigned     rec_budget;
    out_item_t       due_results[$];
    int unsigned     errors;

    function new();
      count       = 0;
      bytes       = 0;
      failed      = 1'b0;
      released    = 1'b0;
      authed      = 1'b0;
      bound       = 1'b0;
      rdy_local   = 1'b0;
      rdy_remote  = 1'b0;
      byte_budget = 64'(BYTE_BUDGET_RST);
      rec_budget  = REC_BUDGET_RST;
      errors      = 0;
    endfunction

    function void set_reg(logic idx, logic [BYTE_COUNT_BITS_DEF-1:0] v);
      if (idx == CFG_BYTE_BUDGET) begin
        byte_budget = 64'(v);
      end else begin
        rec_budget = 32'(v[REC_BUDGET_W-1:0]);
      end
    endfunction

    function bit gate_open();
      return authed && bound && rdy_local && rdy_remote;
    endfunction

    function logic [2:0] gate_status();
      return gate_open() ? ST_RELEASED : ST_BLOCKED;
    endfunction

    function logic [2:0] latch_failure(logic [2:0] st);
      count  = 0;
      bytes  = 0;
      failed = 1'b1;
      return st;
    endfunction

    // true when a record of this length stays within both budgets
    function bit fits(logic [15:0] len);
      longint unsigned cost;
      cost = longint'(len) + PREFIX_BYTES;
      return count < rec_budget && count < MAX_RECORDS_DEF &&
             cost <= byte_budget && bytes <= byte_budget - cost;
    endfunction

    function logic [2:0] enqueue(in_item_t c);
      if (byte_budget == 0 || rec_budget == 0 || c.flow_id == '0 ||
          c.flow_seq == '0 || c.frame_tag == '0 || !c.type_name_present)
        return ST_INVALID;
      if (failed || released || gate_open())
        return ST_CLOSED;
      for (int i = 0; i < count; i++)
        if (held[i].sid == c.flow_id && held[i].seq == c.flow_seq)
          return latch_failure(ST_VIOLATION);
      if (!fits(c.payload_length))
        return latch_failure(ST_BACKPRESSURE);
      held[count] = '{c.flow_id, c.flow_seq, c.frame_tag,
                      c.payload_length, c.payload_handle};
      count++;
      bytes += longint'(c.payload_length) + PREFIX_BYTES;
      return ST_QUEUED;
    endfunction

    // note an accepted command transfer
    function void take_command(in_item_t c);
      out_item_t  r;
      logic [2:0] st;
      bit         drained;
      r       = '0;
      r.last  = 1'b1;
      drained = 1'b0;
      case (c.command)
        CMD_ENQUEUE: st = enqueue(c);
        CMD_AUTH: begin
          if (failed || released) begin
            st = ST_CLOSED;
          end else if (!(c.hs_done && c.pin_ok && c.exporter_ok)) begin
            st = latch_failure(ST_VIOLATION);
          end else begin
            authed = 1'b1;
            st     = gate_status();
          end
        end
        CMD_BIND: begin
          if (failed || released) begin
            st = ST_CLOSED;
          end else if (!authed) begin
            st = latch_failure(ST_VIOLATION);
          end else begin
            bound = 1'b1;
            st    = gate_status();
          end
        end
        CMD_LINK: begin
          if (failed || released) begin
            st = ST_CLOSED;
          end else if (!bound) begin
            st = latch_failure(ST_VIOLATION);
          end else begin
            rdy_local  = rdy_local || c.local_side_ready;
            rdy_remote = rdy_remote || c.remote_side_ready;
            st         = gate_status();
          end
        end
        CMD_RELEASE: begin
          if (failed) begin
            st = ST_CLOSED;
          end else if (released) begin
            st = ST_RELEASED;
          end else if (!gate_open()) begin
            st = ST_BLOCKED;
          end else begin
            st       = ST_RELEASED;
            released = 1'b1;
            // an empty drain still gives one empty result
            drained  = count != 0;
            for (int i = 0; i < count; i++) begin
              r.status        = ST_RELEASED;
              r.record_valid  = 1'b1;
              r.out_flow_id   = held[i].sid;
              r.out_sequence  = held[i].seq;
              r.out_tag       = held[i].tag;
              r.out_length    = held[i].len;
              r.out_handle    = held[i].hnd;
              r.last          = (i + 1 == count);
              due_results     = {due_results, r};
            end
            count = 0;
            bytes = 0;
          end
        end
        default: st = ST_INVALID;
      endcase
      if (!drained) begin
        r.status    = st;
        due_results = {due_results, r};
      end
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // check one result transfer against the oldest expectation
    function void match_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("record_valid", want.record_valid, got.record_valid);
      check_field("out_flow_id", want.out_flow_id, got.out_flow_id);
      check_field("out_sequence", want.out_sequence, got.out_sequence);
      check_field("out_tag", want.out_tag, got.out_tag);
      check_field("out_length", want.out_length, got.out_length);
      check_field("out_handle", want.out_handle, got.out_handle);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  // Every input starts at a known value.
  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           start     = 1'b0;
  logic                           busy;
  in_item_t                       cmd_bus   = '0;
  logic                           out_strobe;
  out_item_t                      out_item;
  logic                           cfg_we    = 1'b0;
  logic                           cfg_index = 1'b0;
  logic [BYTE_COUNT_BITS_DEF-1:0] cfg_data  = '0;

  hold_queue_mirror mirror = new();
  bit               idle_on = 1'b1;

  gated_record_hold_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (cmd_bus),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Results cannot be held off: every strobed cycle is a transfer.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      mirror.match_result(out_item);
    end
  end

  // Fully random command: every field, every bit, codes 5..7 included.
  function automatic in_item_t noise_item();
    in_item_t c;
    c.command           = 3'($urandom_range(0, 7));
    c.flow_id           = {$urandom, $urandom};
    c.flow_seq          = {$urandom, $urandom};
    c.frame_tag         = $urandom;
    c.type_name_present = 1'($urandom_range(0, 1));
    c.payload_length    = 16'($urandom);
    c.payload_handle    = $urandom;
    c.hs_done           = 1'($urandom_range(0, 1));
    c.pin_ok            = 1'($urandom_range(0, 1));
    c.exporter_ok       = 1'($urandom_range(0, 1));
    c.local_side_ready  = 1'($urandom_range(0, 1));
    c.remote_side_ready = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Well-formed enqueue with random content; lengths mostly small so that
  // the store can fill up under the default byte budget.
  function automatic in_item_t record_item();
    in_item_t c;
    c                   = noise_item();
    c.command           = CMD_ENQUEUE;
    c.type_name_present = 1'b1;
    if (c.flow_id == '0) c.flow_id = 64'd1;
    if (c.flow_seq == '0) c.flow_seq = 64'd1;
    if (c.frame_tag == '0) c.frame_tag = 32'd1;
    case ($urandom_range(0, 9))
      0:       c.payload_length = 16'hFFFF;
      1:       c.payload_length = 16'($urandom);
      default: c.payload_length = 16'($urandom_range(0, 2000));
    endcase
    return c;
  endfunction

  function automatic in_item_t make_record(logic [63:0] sid, logic [63:0] seq,
                                           logic [31:0] tag, logic [15:0] len,
                                           logic [31:0] hnd);
    in_item_t c;
    c                 = record_item();
    c.flow_id         = sid;
    c.flow_seq        = seq;
    c.frame_tag       = tag;
    c.payload_length  = len;
    c.payload_handle  = hnd;
    return c;
  endfunction

  // Next random command, shaped by where the queue stands so that most of
  // the run walks the fill / gate / drain path rather than the closed state.
  function automatic in_item_t shaped_item(int k);
    in_item_t    c;
    held_rec_t   dup;
    int unsigned r;
    c = noise_item();
    r = $urandom_range(0, 99);
    if (mirror.failed || mirror.released) return c;  // closed for good
    if (r < 45) begin
      c = record_item();
      if (k >= FATAL_FROM && r < 3 && mirror.count > 0) begin
        // repeat of a held key
        dup        = mirror.held[$urandom_range(0, mirror.count - 1)];
        c.flow_id  = dup.sid;
        c.flow_seq = dup.seq;
      end else if (r < 8 && mirror.count > 0) begin
        // same stream, fresh sequence: legal
        c.flow_id = mirror.held[$urandom_range(0, mirror.count - 1)].sid;
      end
      // keep the store alive until the fatal window opens
      if (k < FATAL_FROM && !mirror.fits(c.payload_length)) c.frame_tag = '0;
    end else if (r < 60) begin
      c = record_item();
      case ($urandom_range(0, 4))
        0:       c.flow_id = '0;
        1:       c.flow_seq = '0;
        2:       c.frame_tag = '0;
        3:       c.type_name_present = 1'b0;
        default: c.command = 3'($urandom_range(5, 7));
      endcase
    end else if (r < 70) begin
      c.command = CMD_RELEASE;
    end else if (k >= FATAL_FROM && $urandom_range(0, 19) == 0) begin
      // gate step with its predecessor possibly missing
      c.command = mirror.authed ? CMD_LINK : CMD_BIND;
    end else if (!mirror.authed || r >= 95) begin
      c.command     = CMD_AUTH;
      c.hs_done     = 1'b1;
      c.pin_ok      = 1'b1;
      c.exporter_ok = 1'b1;
      if (k >= FATAL_FROM && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       c.hs_done = 1'b0;
          1:       c.pin_ok = 1'b0;
          default: c.exporter_ok = 1'b0;
        endcase
      end
    end else if (!mirror.bound || r >= 90 || k < LINK_FROM) begin
      c.command = CMD_BIND;
    end else begin
      // sticky ready flags: a few link commands until both are up
      c.command           = CMD_LINK;
      c.local_side_ready  = $urandom_range(0, 3) == 0;
      c.remote_side_ready = $urandom_range(0, 3) == 0;
    end
    return c;
  endfunction

  // Drive one command and wait for its transfer. A zero gap keeps start
  // high straight from the previous transfer.
  task automatic issue(input in_item_t c);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      start   <= 1'b0;
      cmd_bus <= noise_item();
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    cmd_bus <= c;
    do @(posedge clk); while (busy);
    mirror.take_command(c);
  endtask

  // Idle the input and wait until every expected result is in.
  task automatic settle();
    start <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [BYTE_COUNT_BITS_DEF-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic new_budgets();
    logic [BYTE_COUNT_BITS_DEF-1:0] bb;
    logic [BYTE_COUNT_BITS_DEF-1:0] rb;
    case ($urandom_range(0, 7))
      0:       bb = '0;
      1:       bb = BYTE_COUNT_BITS_DEF'($urandom_range(6, 300));
      2:       bb = BYTE_COUNT_BITS_DEF'(BYTE_BUDGET_RST);
      3, 4:    bb = '1;
      default: bb = BYTE_COUNT_BITS_DEF'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       rb = '0;
      1:       rb = BYTE_COUNT_BITS_DEF'(31);
      2:       rb = BYTE_COUNT_BITS_DEF'($urandom);  // upper bits are dropped by the register
      default: rb = BYTE_COUNT_BITS_DEF'($urandom_range(1, 16));
    endcase
    write_reg(CFG_BYTE_BUDGET, bb);
    write_reg(CFG_REC_BUDGET, rb);
  endtask

  initial begin
    in_item_t c;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes under the widest budgets, the refusals, the
    // unknown codes and a release against a closed gate.
    write_reg(CFG_BYTE_BUDGET, '1);
    write_reg(CFG_REC_BUDGET, BYTE_COUNT_BITS_DEF'(16));
    issue(make_record('1, '1, '1, 16'hFFFF, '1));
    issue(make_record(64'd1, 64'd1, 32'd1, 16'd0, 32'd0));
    issue(make_record('1, 64'd1, 32'd7, 16'd0, 32'd5));  // same stream, new sequence
    issue(make_record({1'b1, 63'd0}, {1'b1, 63'd0}, {1'b1, 31'd0}, 16'h8000,
                      {1'b1, 31'd0}));
    c = record_item();
    c.flow_id = '0;
    issue(c);
    c = record_item();
    c.flow_seq = '0;
    issue(c);
    c = record_item();
    c.frame_tag = '0;
    issue(c);
    c = record_item();
    c.type_name_present = 1'b0;
    issue(c);
    for (int code = 5; code <= 7; code++) begin
      c = record_item();
      c.command = 3'(code);
      issue(c);
    end
    c = noise_item();
    c.command = CMD_RELEASE;
    issue(c);

    // zero budgets refuse any enqueue
    settle();
    write_reg(CFG_BYTE_BUDGET, '0);
    issue(record_item());
    settle();
    write_reg(CFG_BYTE_BUDGET, '1);
    write_reg(CFG_REC_BUDGET, '0);
    issue(record_item());
    settle();
    write_reg(CFG_REC_BUDGET, BYTE_COUNT_BITS_DEF'(16));

    // Random: fill and gate first, then the drain or a fatal error, then
    // plain noise against the closed queue.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 50 == 0) idle_on = $urandom_range(0, 3) != 0;
      if (k % CFG_EVERY == CFG_EVERY - 1) begin
        settle();
        new_budgets();
      end
      issue(shaped_item(k));
    end

    settle();
    repeat (20) @(posedge clk);
    if (mirror.errors == 0 && mirror.due_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
src/grhq_pkg.sv
src/gated_record_hold_queue_unit.sv
tb/gated_record_hold_queue_unit_test.sv
